@@ design/integer_to_ascii_formatter_defines.svh @@
// assertion macros for the integer to ascii formatter
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define I2A_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2a check failed");

// next-cycle implication, checked outside reset
`define I2A_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2a check failed");

`endif

@@ design/i2a_pkg.sv @@
// shared types, codes and character helpers of the integer to ascii formatter
`timescale 1ns / 1ps

package i2a_pkg;

   // conversion codes
   localparam logic [2:0] OpSignedDec   = 3'd0;
   localparam logic [2:0] OpUnsignedDec = 3'd1;
   localparam logic [2:0] OpHexLower    = 3'd2;
   localparam logic [2:0] OpHexUpper    = 3'd3;
   localparam logic [2:0] OpPointer     = 3'd4;

   // prefix kinds
   typedef logic [1:0] prefix_type;
   localparam prefix_type PfxNone  = 2'd0;
   localparam prefix_type PfxMinus = 2'd1;
   localparam prefix_type PfxHex   = 2'd2;
   localparam prefix_type PfxNil   = 2'd3;

   // ascii anchors
   localparam logic [6:0] CharZero       = 7'd48;
   localparam logic [6:0] CharLowerBase  = 7'd87;   // 'a' - 10
   localparam logic [6:0] CharUpperBase  = 7'd55;   // 'A' - 10
   localparam logic [6:0] CharMinus      = 7'd45;
   localparam logic [6:0] CharX          = 7'd120;
   localparam logic [6:0] CharOpenParen  = 7'd40;
   localparam logic [6:0] CharCloseParen = 7'd41;
   localparam logic [6:0] CharN          = 7'd110;
   localparam logic [6:0] CharI          = 7'd105;
   localparam logic [6:0] CharL          = 7'd108;

   // one digit nibble to its ascii character
   function automatic logic [6:0] digit_char(input logic [3:0] nib, input logic upper);
      logic [6:0] base;
      if (nib < 4'd10) begin
         base = CharZero;
      end else if (upper) begin
         base = CharUpperBase;
      end else begin
         base = CharLowerBase;
      end
      return base + {3'b000, nib};
   endfunction

   // number of prefix characters
   function automatic logic [2:0] prefix_len(input prefix_type kind);
      logic [2:0] len;
      unique case (kind)
         PfxHex:  len = 3'd2;
         PfxNil:  len = 3'd5;
         default: len = 3'd1;
      endcase
      return len;
   endfunction

   // prefix character at a given position
   function automatic logic [6:0] prefix_char(input prefix_type kind, input logic [2:0] idx);
      logic [6:0] ch;
      ch = CharMinus;
      unique case (kind)
         PfxHex: begin
            ch = (idx == 3'd0) ? CharZero : CharX;
         end
         PfxNil: begin
            unique case (idx)
               3'd0:    ch = CharOpenParen;
               3'd1:    ch = CharN;
               3'd2:    ch = CharI;
               3'd3:    ch = CharL;
               default: ch = CharCloseParen;
            endcase
         end
         default: ch = CharMinus;
      endcase
      return ch;
   endfunction

endpackage

@@ design/integer_to_ascii_formatter.sv @@
// integer to ascii formatter: bit-serial binary to bcd, nibble-serial text output
//
//   channel | direction | handshake       | payload
//   req     | in        | valid / stall   | op, value
//   rsp     | out       | valid / stall   | character, last, text_length
//   csr     | in/out    | apb write/read  | null_text_style at byte address 0
//
// decimal: one shift-add-3 step per bit of the 32-bit value, then the leading zero
// strip over 10 digits; hex: the strip over 8 (32-bit) or 16 (pointer) digits.
// then one character per cycle while rsp_stall does not hold the output register;
// a zero pointer shown as "(nil)" skips the strip, 5 characters.
// req_stall is high from acceptance until the last character enters the output
// register; the next transaction can be taken while that character waits.
// synchronous active-high reset clears control state and null_text_style.
`timescale 1ns / 1ps
`include "integer_to_ascii_formatter_defines.svh"

module integer_to_ascii_formatter
   import i2a_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [63:0] req_value,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_character,
   output logic        rsp_last,
   output logic [4:0]  rsp_text_length,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // sequencer states
   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StConv   = 3'd1;
   localparam logic [2:0] StSkip   = 3'd2;
   localparam logic [2:0] StPrefix = 3'd3;
   localparam logic [2:0] StDigit  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [63:0] dig_ff, dig_in;
   logic [31:0] bin_ff, bin_in;
   logic [4:0]  bit_cnt_ff, bit_cnt_in;
   logic [4:0]  ndig_ff, ndig_in;
   logic [4:0]  cnt_ff, cnt_in;
   prefix_type  pfx_ff, pfx_in;
   logic [2:0]  pidx_ff, pidx_in;
   logic        upper_ff, upper_in;
   logic        style_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  rsp_char_ff, rsp_char_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [4:0]  rsp_len_ff, rsp_len_in;

   logic        req_accept;
   logic        out_free;
   logic        emit_valid;
   logic [6:0]  emit_char;
   logic        emit_last;
   logic [31:0] low_word;
   logic [39:0] bcd_adj;
   logic        csr_write;

   assign req_stall  = (state_ff != StIdle);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign low_word   = req_value[31:0];

   // configuration register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign prdata    = {31'd0, style_ff && (paddr[2] == 1'b0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff <= 1'b0;
      end else if (csr_write) begin
         style_ff <= pwdata[0];
      end
   end

   // add-3 correction on every bcd nibble
   always_comb begin
      logic [3:0] nib;
      for (int i = 0; i < 10; i++) begin
         nib = dig_ff[24 + 4*i +: 4];
         bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
   end

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      dig_in     = dig_ff;
      bin_in     = bin_ff;
      bit_cnt_in = bit_cnt_ff;
      ndig_in    = ndig_ff;
      cnt_in     = cnt_ff;
      pfx_in     = pfx_ff;
      pidx_in    = pidx_ff;
      upper_in   = upper_ff;
      emit_valid = 1'b0;
      emit_char  = CharZero;
      emit_last  = 1'b0;

      unique case (state_ff)
         StIdle: begin
            if (req_accept) begin
               cnt_in   = 5'd0;
               pidx_in  = 3'd0;
               upper_in = (req_op == OpHexUpper);
               unique case (req_op)
                  OpSignedDec, OpUnsignedDec: begin
                     if ((req_op == OpSignedDec) && low_word[31]) begin
                        bin_in = ~low_word + 32'd1;
                        pfx_in = PfxMinus;
                     end else begin
                        bin_in = low_word;
                        pfx_in = PfxNone;
                     end
                     dig_in     = 64'd0;
                     bit_cnt_in = 5'd0;
                     state_in   = StConv;
                  end
                  OpHexLower, OpHexUpper: begin
                     dig_in   = {low_word, 32'd0};
                     ndig_in  = 5'd8;
                     pfx_in   = PfxNone;
                     state_in = StSkip;
                  end
                  OpPointer: begin
                     if ((req_value == 64'd0) && !style_ff) begin
                        pfx_in   = PfxNil;
                        state_in = StPrefix;
                     end else begin
                        dig_in   = req_value;
                        ndig_in  = 5'd16;
                        pfx_in   = PfxHex;
                        state_in = StSkip;
                     end
                  end
                  default: state_in = StIdle;
               endcase
            end
         end
         StConv: begin
            // shift one binary bit into the corrected bcd digits
            dig_in[63:24] = {bcd_adj[38:0], bin_ff[31]};
            bin_in        = {bin_ff[30:0], 1'b0};
            bit_cnt_in    = bit_cnt_ff + 5'd1;
            if (bit_cnt_ff == 5'd31) begin
               ndig_in  = 5'd10;
               state_in = StSkip;
            end
         end
         StSkip: begin
            // drop leading zero digits, keeping at least one
            if ((dig_ff[63:60] == 4'd0) && (ndig_ff > 5'd1)) begin
               dig_in  = {dig_ff[59:0], 4'd0};
               ndig_in = ndig_ff - 5'd1;
            end else begin
               state_in = (pfx_ff == PfxNone) ? StDigit : StPrefix;
            end
         end
         StPrefix: begin
            emit_valid = 1'b1;
            emit_char  = prefix_char(pfx_ff, pidx_ff);
            emit_last  = (pfx_ff == PfxNil) && (pidx_ff == prefix_len(pfx_ff) - 3'd1);
            if (out_free) begin
               cnt_in  = cnt_ff + 5'd1;
               pidx_in = pidx_ff + 3'd1;
               if (pidx_ff == prefix_len(pfx_ff) - 3'd1) begin
                  state_in = (pfx_ff == PfxNil) ? StIdle : StDigit;
               end
            end
         end
         StDigit: begin
            emit_valid = 1'b1;
            emit_char  = digit_char(dig_ff[63:60], upper_ff);
            emit_last  = (ndig_ff == 5'd1);
            if (out_free) begin
               dig_in  = {dig_ff[59:0], 4'd0};
               ndig_in = ndig_ff - 5'd1;
               cnt_in  = cnt_ff + 5'd1;
               if (ndig_ff == 5'd1) begin
                  state_in = StIdle;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   // output register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_len_in   = rsp_len_ff;
      if (out_free) begin
         rsp_valid_in = emit_valid;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
         rsp_len_in   = emit_last ? cnt_ff + 5'd1 : 5'd0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      dig_ff      <= dig_in;
      bin_ff      <= bin_in;
      bit_cnt_ff  <= bit_cnt_in;
      ndig_ff     <= ndig_in;
      cnt_ff      <= cnt_in;
      pfx_ff      <= pfx_in;
      pidx_ff     <= pidx_in;
      upper_ff    <= upper_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_character   = rsp_char_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_text_length = rsp_len_ff;

   // checks on sequencing and length tagging
   `I2A_ASSERT_NXT(a_valid_op_leaves_idle, clock, reset, req_accept && (req_op <= OpPointer), state_ff != StIdle)
   `I2A_ASSERT_IMP(a_len_only_on_last, clock, reset, rsp_valid, rsp_last == (rsp_text_length != 5'd0))
   `I2A_ASSERT_IMP(a_len_bounded, clock, reset, rsp_valid, rsp_text_length <= 5'd18)
   `I2A_ASSERT_IMP(a_digits_remaining, clock, reset, state_ff == StDigit, ndig_ff != 5'd0)

endmodule

@@ tb/i2a_text_checker.sv @@
// transaction monitor, text predictor and scoreboard for the integer to ascii formatter
`timescale 1ns / 1ps

module i2a_text_checker
   import i2a_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [63:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [6:0]  rsp_character,
   input  logic        rsp_last,
   input  logic [4:0]  rsp_text_length,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          failures,
   output int          outstanding
);

   localparam logic [2:0] AddrNullStyle = 3'd0;
   localparam logic [6:0] LetterLowerA  = 7'd97;
   localparam logic [6:0] LetterUpperA  = 7'd65;

   typedef struct packed {
      logic [6:0] character;
      logic       last;
      logic [4:0] text_length;
   } glyph_type;

   glyph_type expected_text[$];
   logic      null_style;

   // builds the text of one number and queues its characters
   task automatic predict_text(input logic [2:0] op, input logic [63:0] value);
      logic [6:0]  text [0:17];
      logic [6:0]  rev [0:19];
      logic [31:0] low;
      logic [63:0] mag;
      logic [63:0] radix;
      logic [3:0]  dig;
      logic        upper;
      logic        numeric;
      int          n;
      int          nd;
      int          k;
      n = 0;
      nd = 0;
      low = value[31:0];
      mag = {32'd0, low};
      radix = 64'd10;
      upper = 1'b0;
      numeric = 1'b1;
      case (op)
         OpSignedDec: begin
            // minus sign, then the magnitude; the most negative value negates to itself
            if (low[31]) begin
               text[0] = CharMinus;
               n = 1;
               mag = {32'd0, ~low + 32'd1};
            end
         end
         OpUnsignedDec: begin
            radix = 64'd10;
         end
         OpHexLower: begin
            radix = 64'd16;
         end
         OpHexUpper: begin
            radix = 64'd16;
            upper = 1'b1;
         end
         OpPointer: begin
            if (value == 64'd0) begin
               // null pointer text depends on the style register
               numeric = 1'b0;
               if (null_style) begin
                  text[0] = CharZero;
                  text[1] = CharX;
                  text[2] = CharZero;
                  n = 3;
               end else begin
                  text[0] = CharOpenParen;
                  text[1] = CharN;
                  text[2] = CharI;
                  text[3] = CharL;
                  text[4] = CharCloseParen;
                  n = 5;
               end
            end else begin
               text[0] = CharZero;
               text[1] = CharX;
               n = 2;
               mag = value;
               radix = 64'd16;
            end
         end
         default: begin
            // unused codes print nothing
            return;
         end
      endcase
      if (numeric) begin
         // digits come out least significant first
         do begin
            dig = 4'(mag % radix);
            if (dig < 4'd10) begin
               rev[nd] = CharZero + {3'd0, dig};
            end else if (upper) begin
               rev[nd] = LetterUpperA + {3'd0, dig - 4'd10};
            end else begin
               rev[nd] = LetterLowerA + {3'd0, dig - 4'd10};
            end
            mag = mag / radix;
            nd++;
         end while (mag != 64'd0);
         while (nd > 0) begin
            nd--;
            text[n] = rev[nd];
            n++;
         end
      end
      for (k = 0; k < n; k++) begin
         expected_text.push_back('{text[k], (k == n - 1), (k == n - 1) ? 5'(n) : 5'd0});
      end
   endtask

   // sample both channels and the register port on every rising edge
   always @(posedge clock) begin
      glyph_type want;
      if (reset) begin
         expected_text.delete();
         null_style = 1'b0;
         failures = 0;
      end else begin
         // register port, decoded by word index
         if (psel && penable && pready) begin
            if (pwrite) begin
               if ((paddr >> 2) == (AddrNullStyle >> 2)) begin
                  null_style = pwdata[0];
               end
            end else if ((paddr >> 2) == (AddrNullStyle >> 2)) begin
               if (prdata !== {31'd0, null_style}) begin
                  $error("prdata: expected %0h, got %0h", {31'd0, null_style}, prdata);
                  failures++;
               end
            end
         end
         // result transaction against the oldest expected character
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $error("character: expected none, got %0d", rsp_character);
               failures++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_character !== want.character) begin
                  $error("character: expected %0d, got %0d", want.character, rsp_character);
                  failures++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  failures++;
               end
               if (rsp_text_length !== want.text_length) begin
                  $error("text_length: expected %0d, got %0d", want.text_length,
                         rsp_text_length);
                  failures++;
               end
            end
         end
         // input transaction
         if (req_valid && !req_stall) begin
            predict_text(req_op, req_value);
         end
      end
      outstanding = expected_text.size();
   end

endmodule

@@ tb/tb.sv @@
// stimulus, clock, reset and verdict for the integer to ascii formatter
`timescale 1ns / 1ps

module tb;
   import i2a_pkg::*;

   localparam logic [2:0] AddrNullStyle = 3'd0;
   localparam logic [2:0] AddrUnmapped  = 3'd4;
   localparam int         DrainCycles   = 80;
   localparam int         PhaseItems    = 55;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_op;
   logic [63:0] req_value;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [6:0]  rsp_character;
   logic        rsp_last;
   logic [4:0]  rsp_text_length;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   logic        quiet = 1'b0;
   int          failures;
   int          outstanding;

   integer_to_ascii_formatter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_character(rsp_character),
      .rsp_last(rsp_last), .rsp_text_length(rsp_text_length),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   i2a_text_checker text_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_character(rsp_character),
      .rsp_last(rsp_last), .rsp_text_length(rsp_text_length),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready),
      .failures(failures), .outstanding(outstanding)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // random back-pressure on the result channel
   always @(negedge clock) begin
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 25);
   end

   // one transaction on the input channel, entered and left at a falling edge
   task automatic send_item(input logic [2:0] op, input logic [63:0] value);
      while (!quiet && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // apb setup and access cycles
   task automatic csr_access(input logic write, input logic [2:0] addr,
                             input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // drain all expected characters, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // mix of random, short, sign-boundary and all-ones numbers
   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: v = 64'($urandom_range(0, 20));
         1: v = v >> $urandom_range(1, 63);
         2: v = {v[63:32], 32'h8000_0000 | 32'($urandom_range(0, 3))};
         3: v = {v[63:32], 32'hFFFF_FFFF - 32'($urandom_range(0, 20))};
         4: v = 64'd0;
         default: v = v;
      endcase
      return v;
   endfunction

   initial begin
      int        count;
      int        phase;
      logic [2:0] op;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OpSignedDec;
      req_value = 64'd0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = AddrNullStyle;
      pwdata = 32'd0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, every conversion, sign and null cases
      csr_access(1'b1, AddrNullStyle, 32'd0);
      send_item(OpSignedDec, 64'd0);
      send_item(OpSignedDec, 64'h0000_0000_8000_0000);
      send_item(OpSignedDec, 64'hFFFF_FFFF_7FFF_FFFF);
      send_item(OpSignedDec, 64'h0000_0000_FFFF_FFFF);
      send_item(OpSignedDec, 64'h0000_0000_FFED_2979);
      send_item(OpUnsignedDec, 64'd0);
      send_item(OpUnsignedDec, 64'h0000_0000_FFFF_FFFF);
      send_item(OpUnsignedDec, 64'hAAAA_5555_0000_000A);
      send_item(OpUnsignedDec, 64'd1000000000);
      send_item(OpHexLower, 64'd0);
      send_item(OpHexLower, 64'h0000_0000_DEAD_BEEF);
      send_item(OpHexLower, 64'h1234_5678_FFFF_FFFF);
      send_item(OpHexUpper, 64'h0000_0000_ABCD_EF09);
      send_item(OpHexUpper, 64'hFFFF_FFFF_0000_000F);
      send_item(OpPointer, 64'd0);
      send_item(OpPointer, 64'd1);
      send_item(OpPointer, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(OpPointer, 64'h8000_0000_0000_0000);
      send_item(OpPointer, 64'h0000_7FFE_1234_ABCD);
      send_item(3'd5, 64'h5555_5555_5555_5555);
      send_item(3'd6, 64'd0);
      send_item(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(OpUnsignedDec, 64'd7);

      // write to an unmapped register leaves the null text alone
      wait_idle();
      csr_access(1'b1, AddrUnmapped, 32'd1);
      csr_access(1'b0, AddrNullStyle, 32'd0);
      send_item(OpPointer, 64'd0);
      wait_idle();
      csr_access(1'b1, AddrNullStyle, 32'hFFFF_FFFF);
      csr_access(1'b0, AddrNullStyle, 32'd0);
      send_item(OpPointer, 64'd0);
      send_item(OpPointer, 64'h10);

      // random phases, register changed between them, second phase without idling
      for (phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: csr_access(1'b1, AddrNullStyle, 32'd0);
            1: csr_access(1'b1, AddrNullStyle, 32'd1);
            default: csr_access(1'b1, AddrNullStyle, $urandom);
         endcase
         csr_access(1'b0, AddrNullStyle, 32'd0);
         quiet = (phase == 1);
         count = 0;
         while (count < PhaseItems) begin
            if ($urandom_range(0, 99) < 6) begin
               op = 3'(5 + $urandom_range(0, 2));
            end else begin
               op = 3'($urandom_range(0, 4));
               count++;
            end
            send_item(op, pick_value());
         end
         quiet = 1'b0;
      end

      wait_idle();
      if (failures == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/i2a_pkg.sv
design/integer_to_ascii_formatter.sv
tb/i2a_text_checker.sv
tb/tb.sv
